[sv/urb_pkg.sv]
// Shared types, opcodes, register indexes and ring index helpers for the
// serial port ring buffer engine. Depends on nothing; every file but urb_ram imports it.
package urb_pkg;

    localparam int RING_DEPTH_DEF = 64;

    localparam logic [1:0] OP_RX_BYTE    = 2'd0;
    localparam logic [1:0] OP_HOST_WRITE = 2'd1;
    localparam logic [1:0] OP_HOST_READ  = 2'd2;
    localparam logic [1:0] OP_TX_DONE    = 2'd3;

    localparam logic [1:0] REG_RX_SIZE  = 2'd0;
    localparam logic [1:0] REG_TX_SIZE  = 2'd1;
    localparam logic [1:0] REG_ECHO     = 2'd2;
    localparam logic [1:0] REG_ESC_CHAR = 2'd3;

    localparam logic [6:0] RST_RX_SIZE  = 7'd64;
    localparam logic [6:0] RST_TX_SIZE  = 7'd64;
    localparam logic       RST_ECHO     = 1'b0;
    localparam logic [7:0] RST_ESC_CHAR = 8'd10;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] data_byte;
    } t_in;

    typedef struct packed {
        logic [7:0] read_data;
        logic       read_valid;
        logic       write_accepted;
        logic [7:0] tx_data;
        logic       tx_valid;
        logic       escape_seen;
        logic       overflow_sticky;
    } t_out;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } t_rx_cmd;

    typedef struct packed {
        logic nonempty;
        logic overflow;
    } t_rx_stat;

    typedef struct packed {
        logic       push;
        logic       done;
        logic [7:0] data;
    } t_tx_cmd;

    typedef struct packed {
        logic accepted;
        logic started;
    } t_tx_stat;

    function automatic logic [8:0] f_eff_size(input logic [6:0] size, input logic [8:0] depth);
        logic [8:0] s;
        s = {2'b00, size};
        if (s < 9'd2) begin
            return 9'd2;
        end else if (s > depth) begin
            return depth;
        end
        return s;
    endfunction

    function automatic logic [8:0] f_advance(input logic [8:0] idx, input logic [8:0] size);
        logic [8:0] n;
        n = idx + 9'd1;
        return (n >= size) ? 9'd0 : n;
    endfunction

endpackage

[sv/urb_ram.sv]
// Generic single write port, single read port RAM with registered read data.
// Depends on nothing.
module urb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[sv/urb_rx_ring.sv]
// Receive ring: indices, sticky overflow flag and the receive byte store.
// Depends on urb_pkg and urb_ram.
module urb_rx_ring #(
    parameter int RING_DEPTH = urb_pkg::RING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [6:0]        i_size,
    input  urb_pkg::t_rx_cmd  i_cmd,
    output urb_pkg::t_rx_stat o_stat,
    output logic [7:0]        o_rd_data
);
    import urb_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);

    logic [IW-1:0] r_widx, r_ridx, n_widx, n_ridx;
    logic [IW-1:0] w_wnxt, w_rnxt;
    logic [8:0]    w_eff;
    logic          r_ovf, n_ovf;
    logic          w_nonempty;

    assign w_eff      = f_eff_size(i_size, 9'(RING_DEPTH));
    assign w_wnxt     = IW'(f_advance(9'(r_widx), w_eff));
    assign w_rnxt     = IW'(f_advance(9'(r_ridx), w_eff));
    assign w_nonempty = (r_widx != r_ridx);

    always_comb begin
        n_widx = r_widx;
        n_ridx = r_ridx;
        n_ovf  = r_ovf;
        if (i_cmd.push) begin
            n_widx = w_wnxt;
            if (w_wnxt == r_ridx) begin
                n_ridx = w_rnxt;
                n_ovf  = 1'b1;
            end
        end else if (i_cmd.pop && w_nonempty) begin
            n_ridx = w_rnxt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx <= '0;
            r_ridx <= '0;
            r_ovf  <= 1'b0;
        end else begin
            r_widx <= n_widx;
            r_ridx <= n_ridx;
            r_ovf  <= n_ovf;
        end
    end

    urb_ram #(
        .WIDTH(8),
        .DEPTH(RING_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.push),
        .i_waddr(r_widx),
        .i_wdata(i_cmd.data),
        .i_raddr(r_ridx),
        .o_rdata(o_rd_data)
    );

    assign o_stat.nonempty = w_nonempty;
    assign o_stat.overflow = r_ovf;
endmodule

[sv/urb_tx_ring.sv]
// Transmit ring: indices, transmitter busy flag and the transmit byte store.
// Depends on urb_pkg and urb_ram.
module urb_tx_ring #(
    parameter int RING_DEPTH = urb_pkg::RING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [6:0]        i_size,
    input  urb_pkg::t_tx_cmd  i_cmd,
    output urb_pkg::t_tx_stat o_stat,
    output logic [7:0]        o_tx_data
);
    import urb_pkg::*;

    localparam int IW = $clog2(RING_DEPTH);

    logic [IW-1:0] r_widx, r_ridx, n_widx, n_ridx;
    logic [IW-1:0] w_wnxt, w_rnxt;
    logic [8:0]    w_eff;
    logic          r_busy, n_busy;
    logic          r_byp, n_byp;
    logic [7:0]    r_byp_byte;
    logic [7:0]    w_ram_q;
    logic          w_empty, w_full;
    logic          w_we;

    assign w_eff   = f_eff_size(i_size, 9'(RING_DEPTH));
    assign w_wnxt  = IW'(f_advance(9'(r_widx), w_eff));
    assign w_rnxt  = IW'(f_advance(9'(r_ridx), w_eff));
    assign w_empty = (r_widx == r_ridx);
    assign w_full  = (w_wnxt == r_ridx);
    assign w_we    = i_cmd.push && !w_full;

    always_comb begin
        n_widx          = r_widx;
        n_ridx          = r_ridx;
        n_busy          = r_busy;
        n_byp           = 1'b0;
        o_stat.accepted = 1'b0;
        o_stat.started  = 1'b0;
        if (i_cmd.push) begin
            if (!w_full) begin
                n_widx          = w_wnxt;
                o_stat.accepted = 1'b1;
            end
            // A push into an empty ring with the transmitter idle goes straight out.
            if (w_empty && !r_busy) begin
                n_ridx         = w_rnxt;
                n_busy         = 1'b1;
                n_byp          = 1'b1;
                o_stat.started = 1'b1;
            end
        end else if (i_cmd.done) begin
            if (!w_empty) begin
                n_ridx         = w_rnxt;
                n_busy         = 1'b1;
                o_stat.started = 1'b1;
            end else begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_widx <= '0;
            r_ridx <= '0;
            r_busy <= 1'b0;
            r_byp  <= 1'b0;
        end else begin
            r_widx <= n_widx;
            r_ridx <= n_ridx;
            r_busy <= n_busy;
            r_byp  <= n_byp;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byp_byte <= i_cmd.data;
    end

    urb_ram #(
        .WIDTH(8),
        .DEPTH(RING_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_widx),
        .i_wdata(i_cmd.data),
        .i_raddr(r_ridx),
        .o_rdata(w_ram_q)
    );

    assign o_tx_data = r_byp ? r_byp_byte : w_ram_q;
endmodule

[sv/uart_ring_buffer_engine_top.sv]
// Top level of the serial port ring buffer engine: configuration registers,
// opcode decode and result register. Depends on urb_pkg, urb_rx_ring, urb_tx_ring.
//
// Usage:
// One operation beat is taken at each rising edge where start is high and
// busy is low; busy is always low, so a beat can be issued every cycle.
// The opcode selects a received line byte, a host write, a host read or a
// transmitter done event, and data_byte carries the byte where one applies.
// Exactly one result beat follows each operation, in the cycle after it is
// taken, marked by o_result_valid for a single cycle. The result is drawn from
// the registered read port of the ring stores; throughput is one beat per
// cycle. The receiver has no way to hold results off and must take each
// result beat in the cycle it is shown.
// Configuration registers (ring sizes, echo enable, escape character) are
// written through i_cfg_we, i_cfg_idx and i_cfg_data while no operation is
// in flight. Synchronous reset clears all ring indices, the transmitter
// busy flag and the overflow flag, and loads the register defaults; the
// ring stores are not cleared and are only read after being written.
module uart_ring_buffer_engine_top #(
    parameter int RING_DEPTH = urb_pkg::RING_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  urb_pkg::t_in  i_item,
    output logic          o_result_valid,
    output urb_pkg::t_out o_result,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [7:0]    i_cfg_data
);
    import urb_pkg::*;

    logic [6:0] r_rx_size, r_tx_size;
    logic       r_echo;
    logic [7:0] r_esc;
    logic       w_accept;
    t_rx_cmd    w_rx_cmd;
    t_rx_stat   w_rx_stat;
    t_tx_cmd    w_tx_cmd;
    t_tx_stat   w_tx_stat;
    logic [7:0] w_rx_q, w_tx_q;
    logic       r_valid;
    logic       r_read_valid, r_write_acc, r_tx_valid, r_escape;
    logic       n_read_valid, n_write_acc, n_escape;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_size <= RST_RX_SIZE;
            r_tx_size <= RST_TX_SIZE;
            r_echo    <= RST_ECHO;
            r_esc     <= RST_ESC_CHAR;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_RX_SIZE:  r_rx_size <= i_cfg_data[6:0];
                REG_TX_SIZE:  r_tx_size <= i_cfg_data[6:0];
                REG_ECHO:     r_echo    <= i_cfg_data[0];
                REG_ESC_CHAR: r_esc     <= i_cfg_data;
                default:      r_esc     <= r_esc;
            endcase
        end
    end

    always_comb begin
        w_rx_cmd     = '{push: 1'b0, pop: 1'b0, data: i_item.data_byte};
        w_tx_cmd     = '{push: 1'b0, done: 1'b0, data: i_item.data_byte};
        n_read_valid = 1'b0;
        n_write_acc  = 1'b0;
        n_escape     = 1'b0;
        if (w_accept) begin
            unique case (i_item.opcode)
                OP_RX_BYTE: begin
                    w_rx_cmd.push = 1'b1;
                    w_tx_cmd.push = r_echo;
                    n_escape      = (i_item.data_byte == r_esc);
                end
                OP_HOST_WRITE: begin
                    w_tx_cmd.push = 1'b1;
                    n_write_acc   = w_tx_stat.accepted;
                end
                OP_HOST_READ: begin
                    w_rx_cmd.pop = 1'b1;
                    n_read_valid = w_rx_stat.nonempty;
                end
                OP_TX_DONE: begin
                    w_tx_cmd.done = 1'b1;
                end
                default: begin
                    w_tx_cmd.done = 1'b0;
                end
            endcase
        end
    end

    urb_rx_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_rx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_size   (r_rx_size),
        .i_cmd    (w_rx_cmd),
        .o_stat   (w_rx_stat),
        .o_rd_data(w_rx_q)
    );

    urb_tx_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_tx (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_size   (r_tx_size),
        .i_cmd    (w_tx_cmd),
        .o_stat   (w_tx_stat),
        .o_tx_data(w_tx_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_valid <= n_read_valid;
        r_write_acc  <= n_write_acc;
        r_tx_valid   <= w_tx_stat.started;
        r_escape     <= n_escape;
    end

    assign o_result_valid           = r_valid;
    assign o_result.read_data       = r_read_valid ? w_rx_q : 8'd0;
    assign o_result.read_valid      = r_read_valid;
    assign o_result.write_accepted  = r_write_acc;
    assign o_result.tx_data         = r_tx_valid ? w_tx_q : 8'd0;
    assign o_result.tx_valid        = r_tx_valid;
    assign o_result.escape_seen     = r_escape;
    assign o_result.overflow_sticky = w_rx_stat.overflow;
endmodule

[sv/urb_checker.sv]
// Port-level checker for the serial port ring buffer engine, bound to the top level.
// Depends on urb_pkg and uart_ring_buffer_engine_top.
module urb_port_props (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          start,
    input logic          busy,
    input urb_pkg::t_in  i_item,
    input logic          o_result_valid,
    input urb_pkg::t_out o_result
);
    import urb_pkg::*;

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_result_valid)
        else $error("Accepted operation beat produced no result beat.");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_result_valid)
        else $error("Result beat appeared without an accepted operation.");

    a_overflow_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && $past(o_result_valid) && $past(o_result.overflow_sticky))
            |-> o_result.overflow_sticky)
        else $error("Overflow flag cleared without a reset.");

    a_read_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.read_valid) |-> ($past(i_item.opcode) == OP_HOST_READ))
        else $error("Read data reported for an operation other than a host read.");

    a_write_ack_only_on_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.write_accepted)
            |-> ($past(i_item.opcode) == OP_HOST_WRITE))
        else $error("Write acknowledge reported for an operation other than a host write.");
endmodule

bind uart_ring_buffer_engine_top urb_port_props u_port_props (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .i_item        (i_item),
    .o_result_valid(o_result_valid),
    .o_result      (o_result)
);
